FILE: rtl/core/mws_pkg.sv
// Shared types, constants and helper functions for the multichannel window statistics block.
package mws_pkg;

    // Field widths
    localparam int SMP_W      = 12;
    localparam int CH_W       = 3;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = 17;
    localparam int Q_W        = 24;
    localparam int WIN_W      = 16;
    localparam int MAG3_W     = 26;
    localparam int FRAC_SHIFT = 12;
    localparam int DVD_W      = SUM_W + MAG3_W - FRAC_SHIFT;
    localparam int EXT_W      = SMP_W + MAG3_W - FRAC_SHIFT;
    localparam int STEP_W     = $clog2(DVD_W);

    // Module parameter defaults
    localparam int DEF_NUM_CHANNELS = 6;
    localparam int DEF_BLOCK_SCANS  = 16;

    // Gain register file
    localparam int NUM_GAINS  = 6;
    localparam int GAIN_IDX_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SCANS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH5     = 3'd6;

    // Saturation limits and reset values
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};
    localparam logic [WIN_W-1:0] WINDOW_SCANS_RST = 16'd1023;
    localparam logic [DVD_W-1:0] Q_POS_MAX = DVD_W'(24'h7FFFFF);
    localparam logic [DVD_W-1:0] Q_NEG_MAG = DVD_W'(24'h800000);

    localparam logic [Q_W-1:0] GAIN_RST [NUM_GAINS] = '{
        24'd184812, 24'd283116, 24'd283116, 24'd1258291, 24'd1258291, 24'd144835
    };

    // One channel's running statistics
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] max;
        logic [SMP_W-1:0] min;
    } stat_entry_t;

    localparam stat_entry_t STAT_RST = '{sum: '0, max: '0, min: SMP_MAX};

    // Request into the scaling unit
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] min;
        logic [SMP_W-1:0] max;
        logic [Q_W-1:0]   gain;
        logic [CNT_W-1:0] count;
    } scale_req_t;

    // Scaled results out of the scaling unit
    typedef struct packed {
        logic [Q_W-1:0] mean;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
    } scale_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_CLOSE_RD,
        ST_CLOSE_CALC,
        ST_CLOSE_WAIT,
        ST_CLOSE_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } sc_state_t;

    // Saturate a truncated magnitude and apply the gain sign
    function automatic logic [Q_W-1:0] sat_signed(input logic [DVD_W-1:0] q,
                                                  input logic neg);
        logic [DVD_W-1:0] lim;
        logic [Q_W-1:0]   res;
        if (q == '0) begin
            res = '0;
        end else if (neg) begin
            lim = (q > Q_NEG_MAG) ? Q_NEG_MAG : q;
            res = Q_W'(~lim + 1'b1);
        end else begin
            lim = (q > Q_POS_MAX) ? Q_POS_MAX : q;
            res = lim[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/mws_stat_mem.sv
// Per-channel statistics memory with registered read and per-entry valid bits.
module mws_stat_mem #(
    parameter int NUM_CHANNELS = mws_pkg::DEF_NUM_CHANNELS,
    parameter int ADDR_W       = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  mws_pkg::stat_entry_t wr_data,
    input  logic                clear_all,
    output mws_pkg::stat_entry_t rd_data
);

    mws_pkg::stat_entry_t mem_reg [NUM_CHANNELS];
    mws_pkg::stat_entry_t rd_raw_reg;
    logic                 rd_vld_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [NUM_CHANNELS-1:0] valid_next;

    // Mark written entries, drop all of them when the window clears
    always_comb begin
        valid_next = valid_reg;
        if (clear_all) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Storage array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, valid bit captured alongside
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_raw_reg <= mem_reg[rd_addr];
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // An entry not written since the last clear reads as its reset value
    assign rd_data = rd_vld_reg ? rd_raw_reg : mws_pkg::STAT_RST;

endmodule

FILE: rtl/core/mws_scale_unit.sv
// Scaling unit: multiplies by 3*|gain|, divides the sum by the scan count, saturates and signs.
module mws_scale_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  mws_pkg::scale_req_t req,
    output logic                done,
    output mws_pkg::scale_res_t res
);

    mws_pkg::sc_state_t state_reg;
    mws_pkg::sc_state_t state_next;

    logic [mws_pkg::SUM_W-1:0]  sum_reg;
    logic [mws_pkg::SMP_W-1:0]  min_reg;
    logic [mws_pkg::SMP_W-1:0]  max_reg;
    logic [mws_pkg::MAG3_W-1:0] mag3_reg;
    logic                       neg_reg;
    logic [mws_pkg::CNT_W-1:0]  cnt_reg;
    logic [mws_pkg::DVD_W-1:0]  quo_reg;
    logic [mws_pkg::CNT_W-1:0]  rem_reg;
    logic [mws_pkg::EXT_W-1:0]  minq_reg;
    logic [mws_pkg::EXT_W-1:0]  maxq_reg;
    logic [mws_pkg::STEP_W-1:0] step_reg;

    logic [mws_pkg::Q_W-1:0]    mag;
    logic [mws_pkg::MAG3_W-1:0] mag3;
    logic [mws_pkg::SUM_W+mws_pkg::MAG3_W-1:0] psum;
    logic [mws_pkg::SMP_W+mws_pkg::MAG3_W-1:0] pmin;
    logic [mws_pkg::SMP_W+mws_pkg::MAG3_W-1:0] pmax;
    logic [mws_pkg::CNT_W:0]    rem_sh;
    logic [mws_pkg::CNT_W:0]    rem_diff;
    logic                       q_bit;
    logic [mws_pkg::DVD_W-1:0]  q_lo;
    logic [mws_pkg::DVD_W-1:0]  q_hi;

    // Gain magnitude times three
    assign mag  = req.gain[mws_pkg::Q_W-1] ? (~req.gain + 1'b1) : req.gain;
    assign mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};

    // Products, one multiplier each, registered before the divide
    assign psum = sum_reg * mag3_reg;
    assign pmin = min_reg * mag3_reg;
    assign pmax = max_reg * mag3_reg;

    // One restoring divide step
    assign rem_sh   = {rem_reg, quo_reg[mws_pkg::DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, cnt_reg};
    assign q_bit    = (rem_sh >= {1'b0, cnt_reg});

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mws_pkg::SC_IDLE: begin
                if (start) begin
                    state_next = mws_pkg::SC_MUL;
                end
            end
            mws_pkg::SC_MUL: begin
                state_next = mws_pkg::SC_DIV;
            end
            mws_pkg::SC_DIV: begin
                if (step_reg == mws_pkg::STEP_W'(mws_pkg::DVD_W - 1)) begin
                    state_next = mws_pkg::SC_DONE;
                end
            end
            mws_pkg::SC_DONE: begin
                state_next = mws_pkg::SC_IDLE;
            end
            default: begin
                state_next = mws_pkg::SC_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        case (state_reg)
            mws_pkg::SC_DONE: done = 1'b1;
            default:          done = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mws_pkg::SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: latch, multiply, then one quotient bit per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            mws_pkg::SC_IDLE: begin
                if (start) begin
                    sum_reg  <= req.sum;
                    min_reg  <= req.min;
                    max_reg  <= req.max;
                    mag3_reg <= mag3;
                    neg_reg  <= req.gain[mws_pkg::Q_W-1];
                    cnt_reg  <= req.count;
                end
            end
            mws_pkg::SC_MUL: begin
                quo_reg  <= psum[mws_pkg::SUM_W+mws_pkg::MAG3_W-1:mws_pkg::FRAC_SHIFT];
                minq_reg <= pmin[mws_pkg::SMP_W+mws_pkg::MAG3_W-1:mws_pkg::FRAC_SHIFT];
                maxq_reg <= pmax[mws_pkg::SMP_W+mws_pkg::MAG3_W-1:mws_pkg::FRAC_SHIFT];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            mws_pkg::SC_DIV: begin
                rem_reg  <= q_bit ? rem_diff[mws_pkg::CNT_W-1:0]
                                  : rem_sh[mws_pkg::CNT_W-1:0];
                quo_reg  <= {quo_reg[mws_pkg::DVD_W-2:0], q_bit};
                step_reg <= step_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Saturate and sign; a negative gain swaps minimum and maximum
    assign q_lo = mws_pkg::DVD_W'(minq_reg);
    assign q_hi = mws_pkg::DVD_W'(maxq_reg);
    assign res.mean = mws_pkg::sat_signed(quo_reg, neg_reg);
    assign res.lo   = neg_reg ? mws_pkg::sat_signed(q_hi, neg_reg)
                              : mws_pkg::sat_signed(q_lo, neg_reg);
    assign res.hi   = neg_reg ? mws_pkg::sat_signed(q_lo, neg_reg)
                              : mws_pkg::sat_signed(q_hi, neg_reg);

endmodule

FILE: rtl/core/multichannel_window_stats.sv
// Top level: sample accumulation, window close sequencing, configuration and result register.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_sample, s_channel
//  m_       out        m_valid / m_ready    m_out_channel, m_mean_volts, m_min_volts,
//                                           m_max_volts, m_last
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// A sample goes through a statistics memory read, then modify and write back.
// A window close reads, scales and outputs the channels one after another, the
// mean through a 42-step restoring divider; no samples are taken during a close.
// Reset clears the per-entry valid bits at once, so there is no clearing pass.
// A stalled m_ready holds the result register; the next result waits behind it.
module multichannel_window_stats #(
    parameter int NUM_CHANNELS = mws_pkg::DEF_NUM_CHANNELS,
    parameter int BLOCK_SCANS  = mws_pkg::DEF_BLOCK_SCANS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mws_pkg::SMP_W-1:0]        s_sample,
    input  logic [mws_pkg::CH_W-1:0]         s_channel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mws_pkg::CH_W-1:0]         m_out_channel,
    output logic signed [mws_pkg::Q_W-1:0]   m_mean_volts,
    output logic signed [mws_pkg::Q_W-1:0]   m_min_volts,
    output logic signed [mws_pkg::Q_W-1:0]   m_max_volts,
    output logic                             m_last,
    input  logic                             cfg_wr_en,
    input  logic [mws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BLK_W  = (BLOCK_SCANS > 1) ? $clog2(BLOCK_SCANS) : 1;
    localparam logic [ADDR_W-1:0] LAST_CH  = ADDR_W'(NUM_CHANNELS - 1);
    localparam logic [BLK_W-1:0]  BLK_LAST = BLK_W'(BLOCK_SCANS - 1);

    mws_pkg::ctl_state_t state_reg;
    mws_pkg::ctl_state_t state_next;

    logic [mws_pkg::WIN_W-1:0] win_reg;
    logic [mws_pkg::Q_W-1:0]   gain_reg [mws_pkg::NUM_GAINS];

    logic [mws_pkg::SMP_W-1:0] smp_reg;
    logic [ADDR_W-1:0]         ch_reg;
    logic [mws_pkg::CNT_W-1:0] scan_reg;
    logic [mws_pkg::CNT_W-1:0] scan_next;
    logic [BLK_W-1:0]          blk_reg;
    logic [BLK_W-1:0]          blk_next;
    logic [ADDR_W-1:0]         idx_reg;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [mws_pkg::CH_W-1:0]  m_ch_reg;
    logic [mws_pkg::Q_W-1:0]   m_mean_reg;
    logic [mws_pkg::Q_W-1:0]   m_min_reg;
    logic [mws_pkg::Q_W-1:0]   m_max_reg;
    logic                      m_last_reg;

    logic                      s_accept;
    logic                      ch_ok;
    logic                      scan_end;
    logic                      close_now;
    logic                      out_free;

    logic                      mem_rd_en;
    logic [ADDR_W-1:0]         mem_rd_addr;
    logic                      mem_wr_en;
    logic                      mem_clear;
    mws_pkg::stat_entry_t      mem_rd_data;
    mws_pkg::stat_entry_t      upd_entry;
    logic [mws_pkg::SUM_W:0]   sum_ext;

    logic                      sc_start;
    logic                      sc_done;
    mws_pkg::scale_req_t       sc_req;
    mws_pkg::scale_res_t       sc_res;
    logic                      out_load;
    logic                      close_end;
    logic [mws_pkg::CFG_IDX_W-1:0] cfg_gidx;

    assign s_accept = s_valid && s_ready;
    assign ch_ok    = (s_channel < mws_pkg::CH_W'(NUM_CHANNELS));
    assign out_free = !m_valid_reg || m_ready;
    assign scan_end = (ch_reg == LAST_CH);
    assign close_end = (idx_reg == LAST_CH);

    // Update the accumulated statistics with the held sample
    assign sum_ext = {1'b0, mem_rd_data.sum} + (mws_pkg::SUM_W + 1)'(smp_reg);
    always_comb begin
        upd_entry.sum = sum_ext[mws_pkg::SUM_W] ? mws_pkg::SUM_MAX
                                                : sum_ext[mws_pkg::SUM_W-1:0];
        upd_entry.max = (smp_reg > mem_rd_data.max) ? smp_reg : mem_rd_data.max;
        upd_entry.min = (smp_reg < mem_rd_data.min) ? smp_reg : mem_rd_data.min;
    end

    // Advance the scan and block counts; both hold once the scan count saturates
    always_comb begin
        scan_next = scan_reg;
        blk_next  = blk_reg;
        if (scan_reg != mws_pkg::CNT_MAX) begin
            scan_next = scan_reg + 1'b1;
            blk_next  = (blk_reg == BLK_LAST) ? '0 : blk_reg + 1'b1;
        end
    end
    assign close_now = (blk_next == '0) &&
                       (scan_next >= mws_pkg::CNT_W'(win_reg));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mws_pkg::ST_IDLE: begin
                if (s_accept && ch_ok) begin
                    state_next = mws_pkg::ST_UPD;
                end
            end
            mws_pkg::ST_UPD: begin
                if (scan_end && close_now) begin
                    state_next = mws_pkg::ST_CLOSE_RD;
                end else begin
                    state_next = mws_pkg::ST_IDLE;
                end
            end
            mws_pkg::ST_CLOSE_RD: begin
                state_next = mws_pkg::ST_CLOSE_CALC;
            end
            mws_pkg::ST_CLOSE_CALC: begin
                state_next = mws_pkg::ST_CLOSE_WAIT;
            end
            mws_pkg::ST_CLOSE_WAIT: begin
                if (sc_done) begin
                    state_next = mws_pkg::ST_CLOSE_OUT;
                end
            end
            mws_pkg::ST_CLOSE_OUT: begin
                if (out_free) begin
                    state_next = close_end ? mws_pkg::ST_IDLE : mws_pkg::ST_CLOSE_RD;
                end
            end
            default: begin
                state_next = mws_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = s_channel[ADDR_W-1:0];
        mem_wr_en   = 1'b0;
        mem_clear   = 1'b0;
        sc_start    = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            mws_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mem_rd_en = s_valid && ch_ok;
            end
            mws_pkg::ST_UPD: begin
                mem_wr_en = 1'b1;
            end
            mws_pkg::ST_CLOSE_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg;
            end
            mws_pkg::ST_CLOSE_CALC: begin
                sc_start = 1'b1;
            end
            mws_pkg::ST_CLOSE_OUT: begin
                out_load  = out_free;
                mem_clear = out_free && close_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mws_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            smp_reg <= s_sample;
            ch_reg  <= s_channel[ADDR_W-1:0];
        end
    end

    // Scan counting, channel walk and window clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            blk_reg  <= '0;
            idx_reg  <= '0;
        end else begin
            if (state_reg == mws_pkg::ST_UPD && scan_end) begin
                scan_reg <= scan_next;
                blk_reg  <= blk_next;
                idx_reg  <= '0;
            end
            if (out_load) begin
                if (close_end) begin
                    scan_reg <= '0;
                    blk_reg  <= '0;
                    idx_reg  <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // Configuration registers
    assign cfg_gidx = cfg_index - mws_pkg::CFG_GAIN_CH0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= mws_pkg::WINDOW_SCANS_RST;
            for (int i = 0; i < mws_pkg::NUM_GAINS; i++) begin
                gain_reg[i] <= mws_pkg::GAIN_RST[i];
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == mws_pkg::CFG_WINDOW_SCANS) begin
                win_reg <= cfg_wdata[mws_pkg::WIN_W-1:0];
            end else if (cfg_index >= mws_pkg::CFG_GAIN_CH0 &&
                         cfg_index <= mws_pkg::CFG_GAIN_CH5) begin
                gain_reg[cfg_gidx[mws_pkg::GAIN_IDX_W-1:0]] <= cfg_wdata[mws_pkg::Q_W-1:0];
            end
        end
    end

    // Statistics memory
    mws_stat_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_stat_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .wr_en     (mem_wr_en),
        .wr_addr   (ch_reg),
        .wr_data   (upd_entry),
        .clear_all (mem_clear),
        .rd_data   (mem_rd_data)
    );

    // Scaling request for the channel being closed
    always_comb begin
        sc_req.sum   = mem_rd_data.sum;
        sc_req.min   = mem_rd_data.min;
        sc_req.max   = mem_rd_data.max;
        sc_req.gain  = gain_reg[mws_pkg::GAIN_IDX_W'(idx_reg)];
        sc_req.count = scan_reg;
    end

    mws_scale_unit u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .req     (sc_req),
        .done    (sc_done),
        .res     (sc_res)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ch_reg   <= mws_pkg::CH_W'(idx_reg);
            m_mean_reg <= sc_res.mean;
            m_min_reg  <= sc_res.lo;
            m_max_reg  <= sc_res.hi;
            m_last_reg <= close_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_ch_reg;
    assign m_mean_volts  = m_mean_reg;
    assign m_min_volts   = m_min_reg;
    assign m_max_volts   = m_max_reg;
    assign m_last        = m_last_reg;

endmodule
